### hw/rtl/slsf_pkg.sv
// shared types, codes and sizes for the serial link stuffing and flow block
// depends on nothing; every module imports it
package slsf_pkg;

   // receive fifo sizing
   localparam int FIFO_DEPTH = 64;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);
   localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

   // job queue between front and back, depth a power of two
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // line codes
   localparam logic [7:0] CODE_XON    = 8'h11;
   localparam logic [7:0] CODE_XOFF   = 8'h13;
   localparam logic [7:0] CODE_SYNC   = 8'h7E;
   localparam logic [7:0] CODE_ESCAPE = 8'h7D;

   // request codes
   localparam logic [1:0] REQ_RX   = 2'd0;
   localparam logic [1:0] REQ_SEND = 2'd1;
   localparam logic [1:0] REQ_POP  = 2'd2;

   // one classified request, ready for beat expansion
   typedef struct packed {
      logic             tx_mode;    // send with flow on
      logic             esc;        // send needs a leading escape
      logic             close_pkt;  // send needs a trailing sync
      logic             pop_valid;
      logic             accepted;
      logic             peer_flow;
      logic [CNT_W-1:0] level;
      logic [7:0]       data;
   } job_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } job_push_type;

   typedef struct packed {
      logic              empty;
      logic [QCNT_W-1:0] count;
   } queue_status_type;

   function automatic logic is_special(input logic [7:0] b);
      return (b == CODE_XON) || (b == CODE_XOFF) || (b == CODE_SYNC) || (b == CODE_ESCAPE);
   endfunction

endpackage

### hw/rtl/slsf_front.sv
// front part: accepts requests, keeps flow/escape state and the receive fifo
// depends on slsf_pkg; feeds slsf_job_queue
module slsf_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   output logic                      req_full,
   input  logic [1:0]                req_type,
   input  logic [7:0]                req_data_byte,
   input  logic                      req_close_packet,
   input  slsf_pkg::queue_status_type q_status,
   output slsf_pkg::job_push_type     job_push
);
   import slsf_pkg::*;

   logic             escape_ff, escape_in;
   logic             flow_ff, flow_in;
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             s1_valid_ff;
   job_type          s1_job_ff, s1_job_in;
   logic             wr_en, rd_en;
   logic [7:0]       rd_q;
   logic [7:0]       rx_mem [FIFO_DEPTH];
   logic             accept;
   logic             try_push;

   // room for this beat plus the one in the stage register
   assign req_full = ({1'b0, q_status.count} + {{QCNT_W{1'b0}}, s1_valid_ff})
                     >= (QCNT_W + 1)'(QUEUE_DEPTH);
   assign accept   = req_push && !req_full;

   // classify the request and update link state
   always_comb begin
      escape_in = escape_ff;
      flow_in   = flow_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      count_in  = count_ff;
      wr_en     = 1'b0;
      rd_en     = 1'b0;
      try_push  = 1'b0;
      s1_job_in = '0;
      s1_job_in.data = req_data_byte;
      case (req_type)
         REQ_RX: begin
            s1_job_in.accepted = 1'b1;
            if (escape_ff) begin
               escape_in = 1'b0;
               try_push  = 1'b1;
            end else if (req_data_byte == CODE_ESCAPE) begin
               escape_in = 1'b1;
            end else if (req_data_byte == CODE_XON) begin
               flow_in = 1'b1;
            end else if (req_data_byte == CODE_XOFF) begin
               flow_in = 1'b0;
            end else begin
               try_push = 1'b1;
            end
            if (try_push) begin
               if (count_ff < CNT_W'(FIFO_DEPTH)) begin
                  wr_en    = 1'b1;
                  head_in  = (head_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : head_ff + 1'b1;
                  count_in = count_ff + 1'b1;
               end else begin
                  s1_job_in.accepted = 1'b0;
               end
            end
         end
         REQ_SEND: begin
            if (flow_ff) begin
               s1_job_in.accepted  = 1'b1;
               s1_job_in.tx_mode   = 1'b1;
               s1_job_in.esc       = is_special(req_data_byte);
               s1_job_in.close_pkt = req_close_packet;
            end
         end
         REQ_POP: begin
            if (count_ff != '0) begin
               rd_en    = 1'b1;
               tail_in  = (tail_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
               count_in = count_ff - 1'b1;
               s1_job_in.accepted  = 1'b1;
               s1_job_in.pop_valid = 1'b1;
            end
         end
         default: begin
            s1_job_in.accepted = 1'b0;
         end
      endcase
      s1_job_in.level     = count_in;
      s1_job_in.peer_flow = flow_in;
   end

   // state and stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         escape_ff   <= 1'b0;
         flow_ff     <= 1'b0;
         head_ff     <= '0;
         tail_ff     <= '0;
         count_ff    <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         if (accept) begin
            escape_ff <= escape_in;
            flow_ff   <= flow_in;
            head_ff   <= head_in;
            tail_ff   <= tail_in;
            count_ff  <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_job_ff <= s1_job_in;
      end
   end

   // receive fifo storage, registered read
   always_ff @(posedge clock) begin
      if (accept && wr_en) begin
         rx_mem[head_ff] <= req_data_byte;
      end
      if (accept && rd_en) begin
         rd_q <= rx_mem[tail_ff];
      end
   end

   // hand the job to the queue, popped byte merged in
   always_comb begin
      job_push.valid = s1_valid_ff;
      job_push.job   = s1_job_ff;
      if (s1_job_ff.pop_valid) begin
         job_push.job.data = rd_q;
      end
   end

endmodule

### hw/rtl/slsf_job_queue.sv
// short job queue between the front and back parts
// depends on slsf_pkg
module slsf_job_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  slsf_pkg::job_push_type     job_push,
   input  logic                       job_pop,
   output slsf_pkg::job_type          job_head,
   output slsf_pkg::queue_status_type q_status
);
   import slsf_pkg::*;

   job_type           qmem [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_pop;

   assign do_pop         = job_pop && (count_ff != '0);
   assign q_status.empty = (count_ff == '0);
   assign q_status.count = count_ff;
   assign job_head       = qmem[rd_ptr_ff];

   // occupancy
   always_comb begin
      count_in = count_ff;
      if (job_push.valid && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!job_push.valid && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   // pointers wrap naturally, depth is a power of two
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (job_push.valid) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (job_push.valid) begin
         qmem[wr_ptr_ff] <= job_push.job;
      end
   end

endmodule

### hw/rtl/slsf_back.sv
// back part: expands each job into one to three result beats
// depends on slsf_pkg; drains slsf_job_queue
module slsf_back (
   input  logic                       clock,
   input  logic                       reset,
   input  slsf_pkg::job_type          job_head,
   input  slsf_pkg::queue_status_type q_status,
   output logic                       job_pop,
   output logic                       rsp_empty,
   input  logic                       rsp_pop,
   output logic                       rsp_tx_valid,
   output logic [7:0]                 rsp_tx_byte,
   output logic                       rsp_pop_valid,
   output logic [7:0]                 rsp_pop_byte,
   output logic                       rsp_accepted,
   output logic [slsf_pkg::CNT_W-1:0] rsp_fifo_level,
   output logic                       rsp_peer_flow,
   output logic                       rsp_last
);
   import slsf_pkg::*;

   logic             out_valid_ff, out_valid_in;
   logic [1:0]       idx_ff, idx_in;
   logic             load;
   logic [1:0]       num_beats;
   logic             beat_last;
   logic             tx_valid_in;
   logic [7:0]       tx_byte_in;
   logic             tx_valid_ff;
   logic [7:0]       tx_byte_ff;
   logic             pop_valid_ff;
   logic [7:0]       pop_byte_ff;
   logic             accepted_ff;
   logic [CNT_W-1:0] level_ff;
   logic             flow_ff;
   logic             last_ff;

   assign load = !out_valid_ff || rsp_pop;

   // beat count and current beat
   always_comb begin
      num_beats = 2'd1;
      if (job_head.tx_mode) begin
         num_beats = 2'd1 + {1'b0, job_head.esc} + {1'b0, job_head.close_pkt};
      end
      beat_last   = (idx_ff == num_beats - 2'd1);
      tx_valid_in = job_head.tx_mode;
      tx_byte_in  = 8'h00;
      if (job_head.tx_mode) begin
         if (job_head.esc && idx_ff == 2'd0) begin
            tx_byte_in = CODE_ESCAPE;
         end else if (idx_ff == {1'b0, job_head.esc}) begin
            tx_byte_in = job_head.data;
         end else begin
            tx_byte_in = CODE_SYNC;
         end
      end
      job_pop      = load && !q_status.empty && beat_last;
      out_valid_in = load ? !q_status.empty : out_valid_ff;
      idx_in       = idx_ff;
      if (load && !q_status.empty) begin
         idx_in = beat_last ? 2'd0 : idx_ff + 2'd1;
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         idx_ff       <= 2'd0;
      end else begin
         out_valid_ff <= out_valid_in;
         idx_ff       <= idx_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (load && !q_status.empty) begin
         tx_valid_ff  <= tx_valid_in;
         tx_byte_ff   <= tx_byte_in;
         pop_valid_ff <= job_head.pop_valid;
         pop_byte_ff  <= job_head.pop_valid ? job_head.data : 8'h00;
         accepted_ff  <= job_head.accepted;
         level_ff     <= job_head.level;
         flow_ff      <= job_head.peer_flow;
         last_ff      <= beat_last;
      end
   end

   assign rsp_empty      = !out_valid_ff;
   assign rsp_tx_valid   = tx_valid_ff;
   assign rsp_tx_byte    = tx_byte_ff;
   assign rsp_pop_valid  = pop_valid_ff;
   assign rsp_pop_byte   = pop_byte_ff;
   assign rsp_accepted   = accepted_ff;
   assign rsp_fifo_level = level_ff;
   assign rsp_peer_flow  = flow_ff;
   assign rsp_last       = last_ff;

endmodule

### hw/rtl/serial_link_stuffing_flow_fifo.sv
// serial link layer: byte stuffing and unstuffing, xon/xoff flow and receive fifo
// stages: front stage register, job queue, back result register
// throughput: one request beat per cycle in while not req_full, one result beat
// per cycle out while popped; one to three beats per send, set by the back expander
// reset: synchronous, active high; clears flow, escape, fifo pointers, queues
// depends on slsf_pkg, slsf_front, slsf_job_queue, slsf_back
module serial_link_stuffing_flow_fifo (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_push,
   output logic                       req_full,
   input  logic [1:0]                 req_type,
   input  logic [7:0]                 req_data_byte,
   input  logic                       req_close_packet,
   output logic                       rsp_empty,
   input  logic                       rsp_pop,
   output logic                       rsp_tx_valid,
   output logic [7:0]                 rsp_tx_byte,
   output logic                       rsp_pop_valid,
   output logic [7:0]                 rsp_pop_byte,
   output logic                       rsp_accepted,
   output logic [slsf_pkg::CNT_W-1:0] rsp_fifo_level,
   output logic                       rsp_peer_flow,
   output logic                       rsp_last
);
   import slsf_pkg::*;

   job_push_type     job_push;
   job_type          job_head;
   queue_status_type q_status;
   logic             job_pop;

   // request classification and link state
   slsf_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_type         (req_type),
      .req_data_byte    (req_data_byte),
      .req_close_packet (req_close_packet),
      .q_status         (q_status),
      .job_push         (job_push)
   );

   // decoupling queue
   slsf_job_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .job_push (job_push),
      .job_pop  (job_pop),
      .job_head (job_head),
      .q_status (q_status)
   );

   // beat expansion and result register
   slsf_back u_back (
      .clock          (clock),
      .reset          (reset),
      .job_head       (job_head),
      .q_status       (q_status),
      .job_pop        (job_pop),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_tx_valid   (rsp_tx_valid),
      .rsp_tx_byte    (rsp_tx_byte),
      .rsp_pop_valid  (rsp_pop_valid),
      .rsp_pop_byte   (rsp_pop_byte),
      .rsp_accepted   (rsp_accepted),
      .rsp_fifo_level (rsp_fifo_level),
      .rsp_peer_flow  (rsp_peer_flow),
      .rsp_last       (rsp_last)
   );

endmodule
